FILE: src/tdde_pkg.sv
// Shared types and constants for the time/date digit entry editor.
// No dependencies; imported by every module of the block.
package tdde_pkg;

  localparam int unsigned NUM_DIGITS = 14;
  localparam logic [3:0]  LAST_POS   = 4'd13;
  localparam logic [7:0]  ASCII_ZERO = 8'd48;
  localparam logic [7:0]  ASCII_NINE = 8'd57;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_RIGHT = 2'd2,
    MODE_KEY   = 2'd3
  } mode_e;

  typedef logic [3:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] digits_t;
  typedef logic [3:0] cursor_t;

  // Decoded field values of one result.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
    cursor_t    cursor;
  } fields_t;

endpackage

FILE: src/tdde_state.sv
// Digit store and cursor with the edit rules for one transaction.
// Depends on tdde_pkg. Outputs the state as it stands after the item.
module tdde_state import tdde_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  mode_e   mode_i,
  input  logic [7:0] key_i,
  output digits_t digits_o,
  output cursor_t cursor_o
);

  digits_t digits_q, digits_d;
  cursor_t cursor_q, cursor_d;
  logic       is_digit;
  logic [7:0] key_off;
  digit_t     k;

  // Position rules; some look at a neighboring digit.
  function automatic logic digit_allowed(cursor_t pos, digit_t kv, digits_t d);
    logic ok;
    ok = 1'b0;
    unique case (pos) inside
      4'd0:        ok = (kv <= 4'd1) || (kv == 4'd2 && d[1] <= 4'd3);
      4'd1:        ok = (d[0] == 4'd2) ? (kv <= 4'd3) : 1'b1;
      4'd2, 4'd4:  ok = (kv <= 4'd5);
      4'd3, 4'd5:  ok = 1'b1;
      4'd6:        ok = (kv <= 4'd2) || (kv == 4'd3 && d[7] <= 4'd1);
      4'd7:        ok = (d[6] == 4'd3) ? (kv <= 4'd1) : 1'b1;
      4'd8:        ok = (kv == 4'd0) || (kv == 4'd1 && d[9] <= 4'd1);
      4'd9:        ok = (d[8] == 4'd1) ? (kv <= 4'd1) : 1'b1;
      4'd10:       ok = (kv == 4'd0);
      4'd11:       ok = (kv <= 4'd1) ||
                        (kv == 4'd2 && d[12] == 4'd0 && d[13] == 4'd0);
      4'd12, 4'd13: ok = (d[11] == 4'd2) ? (kv == 4'd0) : 1'b1;
      default:     ok = 1'b0;
    endcase
    return ok;
  endfunction

  assign is_digit = (key_i >= ASCII_ZERO) && (key_i <= ASCII_NINE);
  assign key_off  = key_i - ASCII_ZERO;
  assign k        = key_off[3:0];

  always_comb begin
    digits_d = digits_q;
    cursor_d = cursor_q;
    unique case (mode_i)
      MODE_CLEAR: begin
        digits_d = '0;
        cursor_d = LAST_POS;
      end
      MODE_LEFT: begin
        if (cursor_q != 4'd0) cursor_d = cursor_q - 4'd1;
      end
      MODE_RIGHT: begin
        if (cursor_q != LAST_POS) cursor_d = cursor_q + 4'd1;
      end
      MODE_KEY: begin
        if (is_digit && cursor_q <= LAST_POS && digit_allowed(cursor_q, k, digits_q)) begin
          digits_d[cursor_q] = k;
        end
      end
      default: begin
        digits_d = digits_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
      cursor_q <= LAST_POS;
    end else if (en_i) begin
      digits_q <= digits_d;
      cursor_q <= cursor_d;
    end
  end

  assign digits_o = digits_d;
  assign cursor_o = cursor_d;

endmodule

FILE: src/tdde_fmt.sv
// Builds the decimal field values from the digit store and cursor.
// Depends on tdde_pkg. Pure combinational.
module tdde_fmt import tdde_pkg::*; (
  input  digits_t digits_i,
  input  cursor_t cursor_i,
  output fields_t fields_o
);

  logic [7:0]  hour_w, minute_w, second_w, day_w, month_w;
  logic [13:0] year_w;

  function automatic logic [7:0] pair_val(digit_t hi, digit_t lo);
    return 8'(hi) * 8'd10 + 8'(lo);
  endfunction

  assign hour_w   = pair_val(digits_i[0], digits_i[1]);
  assign minute_w = pair_val(digits_i[2], digits_i[3]);
  assign second_w = pair_val(digits_i[4], digits_i[5]);
  assign day_w    = pair_val(digits_i[6], digits_i[7]);
  assign month_w  = pair_val(digits_i[8], digits_i[9]);
  assign year_w   = 14'(digits_i[10]) * 14'd1000 + 14'(digits_i[11]) * 14'd100
                  + 14'(digits_i[12]) * 14'd10 + 14'(digits_i[13]);

  assign fields_o.hour   = hour_w[4:0];
  assign fields_o.minute = minute_w[5:0];
  assign fields_o.second = second_w[5:0];
  assign fields_o.day    = day_w[4:0];
  assign fields_o.month  = month_w[3:0];
  assign fields_o.year   = year_w[7:0];
  assign fields_o.cursor = cursor_i;

endmodule

FILE: src/time_date_digit_entry_editor.sv
// Top level of the time/date digit entry editor: stream ports and result register.
// Depends on tdde_pkg, tdde_state and tdde_fmt.
//
// Usage:
//   Slave channel carries one command per transaction: clear, cursor left,
//   cursor right, or an ASCII key. Master channel returns one result per
//   command: hour, minute, second, day, month, year and cursor after the edit.
//   A result is valid in the cycle after its input transaction; throughput is
//   one transaction per cycle while the receiver takes results. The edit and the
//   decimal conversion sit between the state registers and the result register.
//   s_axis_tready_o is high when the result register is empty or being read
//   in the same cycle, so a stalled receiver holds the result and blocks
//   only new input; back-to-back traffic flows while m_axis_tready_i is high.
//   Reset clears all digits and places the cursor on the last year digit,
//   the same as a clear command, and empties the result register.
module time_date_digit_entry_editor import tdde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // mode[1:0], key[9:2], zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // hour[4:0], minute[10:5], second[16:11], day[21:17], month[25:22],
  // year[33:26], cursor[37:34], zero pad
  output logic [39:0] m_axis_tdata_o
);

  logic    s_acc;
  logic    out_valid_q;
  fields_t res_q;
  fields_t fields;
  digits_t digits_nxt;
  cursor_t cursor_nxt;
  mode_e   mode;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign mode            = mode_e'(s_axis_tdata_i[1:0]);

  tdde_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s_acc),
    .mode_i   (mode),
    .key_i    (s_axis_tdata_i[9:2]),
    .digits_o (digits_nxt),
    .cursor_o (cursor_nxt)
  );

  tdde_fmt u_fmt (
    .digits_i (digits_nxt),
    .cursor_i (cursor_nxt),
    .fields_o (fields)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      res_q <= fields;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, res_q.cursor, res_q.year, res_q.month, res_q.day,
                            res_q.second, res_q.minute, res_q.hour};

`ifndef SYNTH
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[37:34] <= LAST_POS)
    else $error("cursor beyond last digit");

  a_fields_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[4:0] <= 5'd23 && m_axis_tdata_o[10:5] <= 6'd59 &&
                         m_axis_tdata_o[16:11] <= 6'd59 && m_axis_tdata_o[21:17] <= 5'd31 &&
                         m_axis_tdata_o[25:22] <= 4'd12 && m_axis_tdata_o[33:26] <= 8'd200))
    else $error("time or date field out of range");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> m_axis_tvalid_o)
    else $error("accepted command produced no result");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tdata_i[1:0] == MODE_CLEAR) |=>
      (m_axis_tdata_o[33:0] == 34'd0 && m_axis_tdata_o[37:34] == LAST_POS))
    else $error("clear did not reset digits and cursor");
`endif

endmodule

FILE: tb/sv/tdde_edit_checker.sv
`timescale 1ns / 1ps
// Checker for the time/date digit entry editor: watches both stream channels,
// predicts every result from accepted commands and compares. Uses tdde_pkg.
module tdde_edit_checker import tdde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [15:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [39:0] m_data_i,
  output int          pending_o,
  output int          mismatch_o
);

  digits_t digit_q;
  cursor_t cursor_q;
  fields_t expected_fields[$];
  fields_t got_f;
  fields_t want_f;
  int      pending_count  = 0;
  int      mismatch_count = 0;

  assign pending_o  = pending_count;
  assign mismatch_o = mismatch_count;

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Entry rules per position; some depend on the neighboring digit.
  function automatic bit digit_fits(cursor_t pos, digit_t k);
    case (pos)
      4'd0:        return k <= 1 || (k == 2 && digit_q[1] <= 3);
      4'd1:        return digit_q[0] == 2 ? k <= 3 : 1'b1;
      4'd2, 4'd4:  return k <= 5;
      4'd3, 4'd5:  return 1'b1;
      4'd6:        return k <= 2 || (k == 3 && digit_q[7] <= 1);
      4'd7:        return digit_q[6] == 3 ? k <= 1 : 1'b1;
      4'd8:        return k == 0 || (k == 1 && digit_q[9] <= 1);
      4'd9:        return digit_q[8] == 1 ? k <= 1 : 1'b1;
      4'd10:       return k == 0;
      4'd11:       return k <= 1 || (k == 2 && digit_q[12] == 0 && digit_q[13] == 0);
      4'd12, 4'd13: return digit_q[11] == 2 ? k == 0 : 1'b1;
      default:     return 1'b0;
    endcase
  endfunction

  // Applies one command to the shadow digits/cursor and returns the decoded fields.
  function automatic fields_t edit_and_decode(mode_e mode, logic [7:0] key);
    digit_t  k;
    int      year;
    fields_t f;
    case (mode)
      MODE_CLEAR: begin
        digit_q  = '0;
        cursor_q = LAST_POS;
      end
      MODE_LEFT: begin
        if (cursor_q != 4'd0) cursor_q = cursor_q - 4'd1;
      end
      MODE_RIGHT: begin
        if (cursor_q != LAST_POS) cursor_q = cursor_q + 4'd1;
      end
      default: begin
        if (key >= ASCII_ZERO && key <= ASCII_NINE) begin
          k = 4'(key - ASCII_ZERO);
          if (cursor_q < NUM_DIGITS && digit_fits(cursor_q, k)) digit_q[cursor_q] = k;
        end
      end
    endcase
    year = int'(digit_q[10]) * 1000 + int'(digit_q[11]) * 100
         + int'(digit_q[12]) * 10 + int'(digit_q[13]);
    f.hour   = 5'(int'(digit_q[0]) * 10 + int'(digit_q[1]));
    f.minute = 6'(int'(digit_q[2]) * 10 + int'(digit_q[3]));
    f.second = 6'(int'(digit_q[4]) * 10 + int'(digit_q[5]));
    f.day    = 5'(int'(digit_q[6]) * 10 + int'(digit_q[7]));
    f.month  = 4'(int'(digit_q[8]) * 10 + int'(digit_q[9]));
    f.year   = 8'(year);
    f.cursor = cursor_q;
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q        = '0;
      cursor_q       = LAST_POS;
      expected_fields.delete();
      pending_count  = 0;
      mismatch_count = 0;
    end else begin
      // Result accepted now belongs to an earlier command: pop before push.
      if (m_valid_i && m_ready_i) begin
        if (expected_fields.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, data %h", m_data_i));
        end else begin
          want_f        = expected_fields.pop_front();
          got_f.hour    = m_data_i[4:0];
          got_f.minute  = m_data_i[10:5];
          got_f.second  = m_data_i[16:11];
          got_f.day     = m_data_i[21:17];
          got_f.month   = m_data_i[25:22];
          got_f.year    = m_data_i[33:26];
          got_f.cursor  = m_data_i[37:34];
          if (got_f.hour != want_f.hour)
            report_mismatch($sformatf("hour %0d, want %0d", got_f.hour, want_f.hour));
          if (got_f.minute != want_f.minute)
            report_mismatch($sformatf("minute %0d, want %0d", got_f.minute, want_f.minute));
          if (got_f.second != want_f.second)
            report_mismatch($sformatf("second %0d, want %0d", got_f.second, want_f.second));
          if (got_f.day != want_f.day)
            report_mismatch($sformatf("day %0d, want %0d", got_f.day, want_f.day));
          if (got_f.month != want_f.month)
            report_mismatch($sformatf("month %0d, want %0d", got_f.month, want_f.month));
          if (got_f.year != want_f.year)
            report_mismatch($sformatf("year %0d, want %0d", got_f.year, want_f.year));
          if (got_f.cursor != want_f.cursor)
            report_mismatch($sformatf("cursor %0d, want %0d", got_f.cursor, want_f.cursor));
        end
      end
      if (s_valid_i && s_ready_i)
        expected_fields.push_back(edit_and_decode(mode_e'(s_data_i[1:0]), s_data_i[9:2]));
      pending_count = expected_fields.size();
    end
  end

endmodule

FILE: tb/sv/time_date_digit_entry_editor_tb.sv
`timescale 1ns / 1ps
// Testbench top for the time/date digit entry editor: clock, reset, command
// stimulus, receiver back-pressure and verdict. Uses tdde_pkg, tdde_edit_checker.
module time_date_digit_entry_editor_tb;
  import tdde_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_START   = 1500;
  localparam int HOLD_CYCLES  = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;   // mode[1:0], key[9:2], zero pad
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // hour[4:0], minute[10:5], second[16:11], day[21:17], month[25:22],
  // year[33:26], cursor[37:34], zero pad
  logic [39:0] m_axis_tdata_o;

  int pending;
  int mismatches;
  int cycle_count = 0;
  int burst_left  = 0;
  int sent_count  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  time_date_digit_entry_editor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  tdde_edit_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_i  (s_axis_tready_o),
    .s_data_i   (s_axis_tdata_i),
    .m_valid_i  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_data_i   (m_axis_tdata_o),
    .pending_o  (pending),
    .mismatch_o (mismatches)
  );

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_cmd(mode_e mode, logic [7:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tdata_i  = {6'd0, key, mode};
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    burst_left--;
    sent_count++;
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] digit_key();
    return ASCII_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Mostly cursor moves and digit keys, with rare clears and arbitrary bytes.
  task automatic send_random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)       send_cmd(MODE_CLEAR, 8'($urandom_range(0, 255)));
    else if (r < 28) send_cmd(MODE_LEFT,  8'($urandom_range(0, 255)));
    else if (r < 48) send_cmd(MODE_RIGHT, 8'($urandom_range(0, 255)));
    else if (r < 90) send_cmd(MODE_KEY,   digit_key());
    else             send_cmd(MODE_KEY,   8'($urandom_range(0, 255)));
  endtask

  // Typing run: clear, walk left to some field, then one or two digits, each run followed by a right move.
  task automatic send_field_entry();
    int steps;
    int len;
    send_cmd(MODE_CLEAR, 8'($urandom_range(0, 255)));
    steps = $urandom_range(0, 14);
    repeat (steps) send_cmd(MODE_LEFT, 8'($urandom_range(0, 255)));
    len = $urandom_range(1, 6);
    repeat (len) begin
      send_cmd(MODE_KEY, digit_key());
      if ($urandom_range(0, 3) != 0) send_cmd(MODE_KEY, digit_key());
      send_cmd(MODE_RIGHT, 8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver: segments of differing stall styles plus one long hold-off.
  initial begin
    int seg_len;
    int style;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && cycle_count > HOLD_START) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      seg_len = $urandom_range(8, 64);
      style   = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(negedge clk_i);
        case (style)
          0:       m_axis_tready_i = 1'b1;
          1:       m_axis_tready_i = 1'($urandom_range(0, 1));
          2:       m_axis_tready_i = ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i = ~m_axis_tready_i;
        endcase
      end
    end
  end

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: ignored keys, the right end stop, year rules, year thousands digit.
    send_cmd(MODE_KEY, ASCII_NINE);
    send_cmd(MODE_RIGHT, 8'h00);
    send_cmd(MODE_KEY, 8'h00);
    send_cmd(MODE_KEY, 8'hFF);
    send_cmd(MODE_KEY, ASCII_ZERO - 8'd1);
    send_cmd(MODE_KEY, ASCII_NINE + 8'd1);
    send_cmd(MODE_LEFT, 8'hFF);
    send_cmd(MODE_KEY, ASCII_ZERO);
    send_cmd(MODE_LEFT, 8'h55);
    send_cmd(MODE_KEY, ASCII_ZERO + 8'd2);   // rejected, low year digits nonzero
    send_cmd(MODE_KEY, ASCII_ZERO + 8'd1);
    send_cmd(MODE_CLEAR, 8'hFF);
    send_cmd(MODE_LEFT, 8'hAA);
    send_cmd(MODE_LEFT, 8'h00);
    send_cmd(MODE_KEY, ASCII_ZERO + 8'd2);   // year 200
    send_cmd(MODE_RIGHT, 8'hFF);
    send_cmd(MODE_KEY, ASCII_ZERO + 8'd5);   // rejected past 200
    send_cmd(MODE_LEFT, 8'h0F);
    send_cmd(MODE_LEFT, 8'hF0);
    send_cmd(MODE_KEY, ASCII_ZERO + 8'd1);   // thousands digit stays zero
    send_cmd(MODE_KEY, ASCII_ZERO);
    wait_results_drained();

    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      if (!paused && sent_count >= RANDOM_ITEMS / 2) begin
        wait_results_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) send_field_entry();
      else send_random_cmd();
    end

    wait_results_drained();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
